[rtl/circle_raster_painter_macros.svh]
// Assertion macros for the circle raster painter RTL.
// Expects a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef CIRCLE_RASTER_PAINTER_MACROS_SVH
`define CIRCLE_RASTER_PAINTER_MACROS_SVH

// Same-cycle implication.
`define CRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/crp_pkg.sv]
// Types and constants for the circle raster painter.
// No dependencies.
`timescale 1ns / 1ps

package crp_pkg;

  localparam int REQ_W     = 2;
  localparam int CRD_W     = 20;
  localparam int RAD_W     = 19;
  localparam int CHAR_W    = 8;
  localparam int POS_W     = 8;
  localparam int STAT_W    = 2;
  localparam int FRAC_W    = 8;
  localparam int ONE_Q8    = 256;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DIM_W = 9;
  localparam int CFG_DAT_W = 9;

  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 9'd256;
  localparam logic [CHAR_W-1:0]    BG_RST     = 8'd32;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_SKIP  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_BG     = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SWEEP  = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

endpackage

[rtl/crp_if.sv]
// Request and result channel interfaces for the circle raster painter.
// Depends on crp_pkg.
`timescale 1ns / 1ps

interface crp_req_if;
  import crp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic                     filled;
  logic signed [CRD_W-1:0]  center_x;
  logic signed [CRD_W-1:0]  center_y;
  logic [RAD_W-1:0]         radius;
  logic [CHAR_W-1:0]        paint_char;
  logic [POS_W-1:0]         read_col;
  logic [POS_W-1:0]         read_row;

  modport source (
    output valid, req_type, filled, center_x, center_y, radius, paint_char,
           read_col, read_row,
    input  ready
  );

  modport sink (
    input  valid, req_type, filled, center_x, center_y, radius, paint_char,
           read_col, read_row,
    output ready
  );
endinterface

interface crp_res_if;
  import crp_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  pixel_char;
  logic [STAT_W-1:0]  status;

  modport source (output valid, pixel_char, status, input ready);
  modport sink   (input valid, pixel_char, status, output ready);
endinterface

[rtl/circle_raster_painter.sv]
// Circle raster painter: character canvas in one synchronous RAM, swept for clear and draw.
// Depends on crp_pkg, crp_if.sv and circle_raster_painter_macros.svh.
`timescale 1ns / 1ps

// One request is handled at a time and gives exactly one result transaction. A clear or a
// draw sweeps the canvas in use one pixel per cycle through the single write port of the
// canvas RAM. A clear then passes through the drain state and the hand-off state before its
// result is registered. A draw runs its distance test in three register stages (offset,
// square, sum) with the compare at the write port, so the drain state waits until the last
// pixels have left the pipeline. A read (whose RAM read is registered at acceptance), a
// skipped draw, an out-of-range read, an empty canvas or an unknown request goes straight
// to the hand-off state, from which its result is registered. A result that still waits in
// the output register holds the block in its hand-off state. Configuration may be written
// only while no request is in flight; a new request is taken while an earlier result still
// waits in the output register.
`include "circle_raster_painter_macros.svh"

module circle_raster_painter #(
  parameter int MAX_DIM = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [crp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [crp_pkg::CFG_DAT_W-1:0]       cfg_data,
  crp_req_if.sink                             req,
  crp_res_if.source                           res
);
  import crp_pkg::*;

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int DX_W   = (((IDX_W + FRAC_W + 1) > CRD_W) ? IDX_W + FRAC_W + 1 : CRD_W) + 1;
  localparam int SQ_W   = 2 * DX_W;
  localparam int D2_W   = SQ_W + 1;
  localparam int R2_W   = 2 * RAD_W;

  // configuration
  logic [CFG_DIM_W-1:0] cfg_width;
  logic [CFG_DIM_W-1:0] cfg_height;
  logic [CHAR_W-1:0]    bg_char;

  // request context
  state_t                  state;
  req_type_t               op;
  logic                    fill;
  logic [CHAR_W-1:0]       paint;
  logic signed [CRD_W-1:0] cx;
  logic signed [CRD_W-1:0] cy;
  logic [RAD_W-1:0]        rad;
  logic [RAD_W-1:0]        rin;
  logic [R2_W-1:0]         r2;
  logic [R2_W-1:0]         rin2;
  logic [IDX_W-1:0]        w_m1;
  logic [IDX_W-1:0]        h_m1;
  logic [IDX_W-1:0]        col;
  logic [IDX_W-1:0]        row;
  status_t                 fin_stat;
  logic                    fin_mem;

  // distance pipeline
  logic                    v1, v2, v3;
  logic signed [DX_W-1:0]  dx1, dy1;
  logic [ADDR_W-1:0]       addr1, addr2, addr3;
  logic [SQ_W-1:0]         sqx2, sqy2;
  logic [D2_W-1:0]         d2_3;

  // canvas memory
  logic [CHAR_W-1:0]       canvas [DEPTH];
  logic [CHAR_W-1:0]       rdata;
  logic                    canvas_we;
  logic [ADDR_W-1:0]       waddr;
  logic [CHAR_W-1:0]       wdata;
  logic                    rd_en;
  logic [ADDR_W-1:0]       raddr;

  // result register
  logic                    out_valid;
  logic [CHAR_W-1:0]       out_pix;
  status_t                 out_stat;

  logic                    in_acc;
  logic                    slot_free;
  logic [DIM_W-1:0]        w_used, h_used;
  logic                    empty;
  logic                    rd_oob;
  logic                    col_last;
  logic                    sweep_last;
  logic                    hit3;
  logic signed [DX_W-1:0]  dx_c, dy_c;
  logic signed [SQ_W-1:0]  sqx_c, sqy_c;

  assign req.ready = (state == S_IDLE);
  assign in_acc    = req.valid && req.ready;
  assign slot_free = !out_valid || res.ready;

  assign res.valid      = out_valid;
  assign res.pixel_char = out_pix;
  assign res.status     = out_stat;

  assign w_used = (int'(cfg_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cfg_width);
  assign h_used = (int'(cfg_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cfg_height);
  assign empty  = (w_used == '0) || (h_used == '0);
  assign rd_oob = (int'(req.read_col) >= int'(w_used)) || (int'(req.read_row) >= int'(h_used));

  assign col_last   = (col == w_m1);
  assign sweep_last = col_last && (row == h_m1);

  assign rd_en = in_acc && (req_type_t'(req.req_type) == REQ_READ) && !rd_oob;
  assign raddr = {IDX_W'(req.read_row), IDX_W'(req.read_col)};

  assign dx_c  = DX_W'(signed'({1'b0, col, {FRAC_W{1'b0}}})) - DX_W'(cx);
  assign dy_c  = DX_W'(signed'({1'b0, row, {FRAC_W{1'b0}}})) - DX_W'(cy);
  assign sqx_c = dx1 * dx1;
  assign sqy_c = dy1 * dy1;
  assign hit3  = (d2_3 <= D2_W'(r2)) && (fill || (d2_3 >= D2_W'(rin2)));

  always_comb begin
    if (op == REQ_CLEAR) begin
      canvas_we = (state == S_SWEEP);
      waddr     = {row, col};
      wdata     = bg_char;
    end else begin
      canvas_we = v3 && hit3;
      waddr     = addr3;
      wdata     = paint;
    end
  end

  always_ff @(posedge clk) begin
    if (canvas_we) begin
      canvas[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= canvas[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= WIDTH_RST;
      cfg_height <= HEIGHT_RST;
      bg_char    <= BG_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  cfg_width  <= CFG_DIM_W'(cfg_data);
        CFG_HEIGHT: cfg_height <= CFG_DIM_W'(cfg_data);
        CFG_BG:     bg_char    <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // request context and counters
  always_ff @(posedge clk) begin
    r2   <= rad * rad;
    rin2 <= rin * rin;
    if (in_acc) begin
      op    <= req_type_t'(req.req_type);
      fill  <= req.filled;
      paint <= req.paint_char;
      cx    <= req.center_x;
      cy    <= req.center_y;
      rad   <= req.radius;
      rin   <= req.radius - RAD_W'(ONE_Q8);
      w_m1  <= IDX_W'(w_used - DIM_W'(1));
      h_m1  <= IDX_W'(h_used - DIM_W'(1));
      col   <= '0;
      row   <= '0;
    end else if (state == S_SWEEP) begin
      col <= col_last ? '0 : col + IDX_W'(1);
      row <= col_last ? row + IDX_W'(1) : row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fin_stat <= ST_DONE;
      fin_mem  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            fin_stat <= ST_DONE;
            fin_mem  <= 1'b0;
            state    <= S_FINISH;
            case (req_type_t'(req.req_type))
              REQ_CLEAR: begin
                if (!empty) begin
                  state <= S_SWEEP;
                end
              end
              REQ_DRAW: begin
                if (int'(req.radius) < ONE_Q8) begin
                  fin_stat <= ST_SKIP;
                end else if (!empty) begin
                  state <= S_SWEEP;
                end
              end
              REQ_READ: begin
                if (rd_oob) begin
                  fin_stat <= ST_RANGE;
                end else begin
                  fin_mem <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_SWEEP: begin
          if (sweep_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2 && !v3) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // distance pipeline: offset, square, sum, compare at the write port
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= (state == S_SWEEP) && (op == REQ_DRAW);
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dx1   <= dx_c;
    dy1   <= dy_c;
    addr1 <= {row, col};
    sqx2  <= sqx_c;
    sqy2  <= sqy_c;
    addr2 <= addr1;
    d2_3  <= D2_W'(sqx2) + D2_W'(sqy2);
    addr3 <= addr2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FINISH) && slot_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && slot_free) begin
      out_pix  <= fin_mem ? rdata : '0;
      out_stat <= fin_stat;
    end
  end

  `CRP_ASSERT_NOW(a_write_in_sweep, canvas_we, (state == S_SWEEP) || (state == S_DRAIN), "canvas write outside a sweep")
  `CRP_ASSERT_NOW(a_pipe_draw_only, v1 || v2 || v3, op == REQ_DRAW, "distance pipeline active without a draw")
  `CRP_ASSERT_NOW(a_idle_pipe_empty, state == S_IDLE, !v1 && !v2 && !v3, "pipeline busy while idle")
  `CRP_ASSERT_NOW(a_count_range, state == S_SWEEP, (col <= w_m1) && (row <= h_m1), "pixel counter beyond canvas")
  `CRP_ASSERT_NEXT(a_finish_result, (state == S_FINISH) && slot_free, out_valid, "finished request gave no result")

endmodule

[tb/sv/circle_raster_painter_tb.sv]
// Self-checking testbench for circle_raster_painter: clear, draw and read transactions
// predicted against a local canvas image, under varying canvas sizes and handshake idling.
// Depends on crp_pkg, crp_if.sv and the circle_raster_painter RTL.
`timescale 1ns / 1ps

module circle_raster_painter_tb;
  import crp_pkg::*;

  localparam int CANVAS_DIM    = 256;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 300000;

  typedef struct {
    req_type_t               kind;
    logic                    filled;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic [RAD_W-1:0]        radius;
    logic [CHAR_W-1:0]       paint;
    logic [POS_W-1:0]        col;
    logic [POS_W-1:0]        row;
  } paint_req_t;

  typedef struct {
    logic [CHAR_W-1:0] pixel;
    status_t           status;
  } pixel_res_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  crp_req_if req_ch ();
  crp_res_if res_ch ();

  circle_raster_painter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the canvas and its registers
  logic [CHAR_W-1:0]    canvas_img [0:CANVAS_DIM*CANVAS_DIM-1];
  logic [CFG_DIM_W-1:0] canvas_w  = WIDTH_RST;
  logic [CFG_DIM_W-1:0] canvas_h  = HEIGHT_RST;
  logic [CHAR_W-1:0]    canvas_bg = BG_RST;

  paint_req_t pending_q [$];
  pixel_res_t expected_q [$];
  paint_req_t cur_req;
  pixel_res_t want;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_token    = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  function automatic int unsigned used_dim(logic [CFG_DIM_W-1:0] v);
    return (v > CANVAS_DIM) ? CANVAS_DIM : v;
  endfunction

  function automatic pixel_res_t render_request(paint_req_t rq);
    pixel_res_t  r;
    int unsigned w, h;
    int          row_i, col_i;
    longint      cx, cy, rad, r2, rin2, dx, dy, d2;
    r.pixel  = '0;
    r.status = ST_DONE;
    w = used_dim(canvas_w);
    h = used_dim(canvas_h);
    case (rq.kind)
      REQ_CLEAR: begin
        for (row_i = 0; row_i < h; row_i++)
          for (col_i = 0; col_i < w; col_i++)
            canvas_img[row_i*CANVAS_DIM + col_i] = canvas_bg;
      end
      REQ_DRAW: begin
        cx  = rq.cx;
        cy  = rq.cy;
        rad = rq.radius;
        if (rad < ONE_Q8) begin
          r.status = ST_SKIP;
        end else begin
          r2   = rad * rad;
          rin2 = (rad - ONE_Q8) * (rad - ONE_Q8);
          for (row_i = 0; row_i < h; row_i++) begin
            dy = longint'(row_i) * ONE_Q8 - cy;
            for (col_i = 0; col_i < w; col_i++) begin
              dx = longint'(col_i) * ONE_Q8 - cx;
              d2 = dx * dx + dy * dy;
              if (d2 <= r2 && (rq.filled || d2 >= rin2))
                canvas_img[row_i*CANVAS_DIM + col_i] = rq.paint;
            end
          end
        end
      end
      REQ_READ: begin
        if (rq.col >= w || rq.row >= h)
          r.status = ST_RANGE;
        else
          r.pixel = canvas_img[int'(rq.row)*CANVAS_DIM + int'(rq.col)];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic paint_req_t build_request(req_type_t k, logic f, int cx, int cy,
                                               int rad, int ch, int col, int row);
    paint_req_t rq;
    rq.kind   = k;
    rq.filled = f;
    rq.cx     = CRD_W'(cx);
    rq.cy     = CRD_W'(cy);
    rq.radius = RAD_W'(rad);
    rq.paint  = CHAR_W'(ch);
    rq.col    = POS_W'(col);
    rq.row    = POS_W'(row);
    return rq;
  endfunction

  // mostly well-formed circles near the canvas, plus raw-field noise
  function automatic paint_req_t random_request();
    paint_req_t  rq;
    int unsigned w, h, pick, span;
    w = used_dim(canvas_w);
    h = used_dim(canvas_h);
    span = ((w > h) ? w : h) + 2;
    rq.filled = 1'($urandom_range(0, 1));
    rq.cx     = CRD_W'($urandom);
    rq.cy     = CRD_W'($urandom);
    rq.radius = RAD_W'($urandom);
    rq.paint  = CHAR_W'($urandom);
    rq.col    = POS_W'($urandom);
    rq.row    = POS_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      rq.kind = REQ_CLEAR;
    end else if (pick < 55) begin
      rq.kind = REQ_DRAW;
      rq.cx = CRD_W'(int'($urandom_range(0, (w + 4) * ONE_Q8)) - 2 * ONE_Q8);
      rq.cy = CRD_W'(int'($urandom_range(0, (h + 4) * ONE_Q8)) - 2 * ONE_Q8);
      if (pick < 47)
        rq.radius = RAD_W'($urandom_range(0, span * ONE_Q8));
      else
        rq.radius = RAD_W'($urandom_range(0, 3 * ONE_Q8));
    end else if (pick < 85) begin
      rq.kind = REQ_READ;
      rq.col  = POS_W'($urandom_range(0, w));
      rq.row  = POS_W'($urandom_range(0, h));
    end else if (pick < 95) begin
      rq.kind = REQ_DRAW;
    end else begin
      rq.kind = REQ_NONE;
    end
    return rq;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= '0;
      req_ch.filled     <= 1'b0;
      req_ch.center_x   <= '0;
      req_ch.center_y   <= '0;
      req_ch.radius     <= '0;
      req_ch.paint_char <= '0;
      req_ch.read_col   <= '0;
      req_ch.read_row   <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_q.push_back(render_request(cur_req));
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          cur_req = pending_q.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.req_type   <= cur_req.kind;
          req_ch.filled     <= cur_req.filled;
          req_ch.center_x   <= cur_req.cx;
          req_ch.center_y   <= cur_req.cy;
          req_ch.radius     <= cur_req.radius;
          req_ch.paint_char <= cur_req.paint;
          req_ch.read_col   <= cur_req.col;
          req_ch.read_row   <= cur_req.row;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transaction pixel_char=%02h status=%0d",
                   $time, res_ch.pixel_char, res_ch.status);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (res_ch.pixel_char !== want.pixel || res_ch.status !== want.status) begin
            $display("%0t: expected pixel_char=%02h status=%0d, got pixel_char=%02h status=%0d",
                     $time, want.pixel, want.status, res_ch.pixel_char, res_ch.status);
            mismatches++;
          end
        end
      end
      if (hold_token != hold_served) begin
        hold_served = hold_token;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_WIDTH:  canvas_w  = value;
      CFG_HEIGHT: canvas_h  = value;
      CFG_BG:     canvas_bg = value[CHAR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int ph;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // full-size canvas: the first clear writes every pixel, so later reads are defined
    pending_q.push_back(build_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(build_request(REQ_DRAW, 0, 128*256, 128*256, 100*256 + 128, 8'h23, 0, 0));
    pending_q.push_back(build_request(REQ_READ, 0, 0, 0, 0, 0, 28, 128));
    pending_q.push_back(build_request(REQ_READ, 0, 0, 0, 0, 0, 255, 255));
    wait_drained();

    write_reg(CFG_WIDTH, 9'd12);
    write_reg(CFG_HEIGHT, 9'd9);
    write_reg(CFG_BG, 9'h1AB);
    pending_q.push_back(build_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(build_request(REQ_DRAW, 1, 1408, 1024, 832, 8'h6F, 0, 0));
    pending_q.push_back(build_request(REQ_DRAW, 0, 1536, 1024, 1024, 8'hFF, 0, 0));
    pending_q.push_back(build_request(REQ_DRAW, 1, 1024, 1024, 255, 8'h21, 0, 0));
    pending_q.push_back(build_request(REQ_DRAW, 0, 1024, 1024, 0, 8'h22, 0, 0));
    pending_q.push_back(build_request(REQ_DRAW, 0, 768, 768, 256, 8'h00, 0, 0));
    pending_q.push_back(build_request(REQ_DRAW, 0, 2560, 1280, 300, 8'h2B, 0, 0));
    pending_q.push_back(build_request(REQ_READ, 0, 0, 0, 0, 0, 10, 5));
    pending_q.push_back(build_request(REQ_DRAW, 1, -524288, 524287, 524287, 8'h58, 0, 0));
    pending_q.push_back(build_request(REQ_DRAW, 0, 524287, -524288, 524287, 8'h55, 0, 0));
    pending_q.push_back(build_request(REQ_DRAW, 1, 0, 0, 524287, 8'h7E, 0, 0));
    pending_q.push_back(build_request(REQ_READ, 0, 0, 0, 0, 0, 11, 8));
    pending_q.push_back(build_request(REQ_READ, 0, 0, 0, 0, 0, 12, 0));
    pending_q.push_back(build_request(REQ_READ, 0, 0, 0, 0, 0, 0, 9));
    pending_q.push_back(build_request(REQ_READ, 0, 0, 0, 0, 0, 255, 255));
    pending_q.push_back(build_request(REQ_NONE, 1, -1, -1, 524287, 255, 255, 255));
    wait_drained();

    // empty canvas
    write_reg(CFG_WIDTH, 9'd0);
    pending_q.push_back(build_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(build_request(REQ_DRAW, 1, 0, 0, 512, 8'h41, 0, 0));
    pending_q.push_back(build_request(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // oversized width saturates
    write_reg(CFG_WIDTH, 9'h1FF);
    write_reg(CFG_HEIGHT, 9'd1);
    write_reg(CFG_BG, 9'd0);
    pending_q.push_back(build_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(build_request(REQ_READ, 0, 0, 0, 0, 0, 255, 0));
    pending_q.push_back(build_request(REQ_READ, 0, 0, 0, 0, 0, 0, 1));
    wait_drained();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 0;  snk_stall_pct = 0;
          write_reg(CFG_WIDTH, 9'd1);
          write_reg(CFG_HEIGHT, 9'd1);
        end
        1: begin
          src_idle_pct = 61; snk_stall_pct = 0;
          write_reg(CFG_WIDTH, 9'd256);
          write_reg(CFG_HEIGHT, 9'd2);
        end
        2: begin
          src_idle_pct = 0;  snk_stall_pct = 61;
          write_reg(CFG_WIDTH, 9'd2);
          write_reg(CFG_HEIGHT, 9'd256);
        end
        default: begin
          src_idle_pct = 35; snk_stall_pct = 35;
          write_reg(CFG_WIDTH, CFG_DAT_W'($urandom_range(1, 24)));
          write_reg(CFG_HEIGHT, CFG_DAT_W'($urandom_range(1, 24)));
        end
      endcase
      write_reg(CFG_BG, CFG_DAT_W'($urandom_range(0, 511)));
      repeat (16) pending_q.push_back(random_request());
      wait_drained();
      if (ph == 0) begin
        // long result back-pressure while requests keep coming
        hold_token <= hold_token + 1;
        repeat (10) pending_q.push_back(random_request());
        wait_drained();
      end
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[circle_raster_painter.f]
+incdir+rtl
rtl/crp_pkg.sv
rtl/crp_if.sv
rtl/circle_raster_painter.sv
tb/sv/circle_raster_painter_tb.sv
